// File: rtl/spa_pkg.sv
// shared constants, types and helpers of the segregated pool allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spa_pkg;

  localparam int unsigned DefHeapChunks = 16;
  localparam int unsigned GranulesPerChunk = 128;
  localparam int unsigned NumClasses = 8;
  localparam int unsigned MaxPoolRequest = 4088;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNull     = 3'd1;
  localparam logic [2:0] StTooLarge = 3'd2;
  localparam logic [2:0] StNoMem    = 3'd3;
  localparam logic [2:0] StBadAddr  = 3'd4;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic        func;
    logic        zero;
    logic        too_large;
    logic        free_null;
    logic [2:0]  cls;
    logic [15:0] base;
  } spa_cmd_t;

  function automatic logic [2:0] class_of(input logic [15:0] bytes);
    logic [16:0] v;
    logic [2:0]  c;
    v = {1'b0, bytes} + 17'd7;
    c = 3'd0;
    for (int i = 5; i <= 11; i++) begin
      if (v[i]) c = 3'(i - 4);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/spa_front.sv
// front end: accepts requests, classifies them and queues them for the back end
// depends on spa_pkg
`timescale 1ns / 1ps
`default_nettype none
module spa_front import spa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [15:0] request_bytes_i,
  input  wire logic [15:0] free_address_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_take_i,
  output spa_cmd_t         cmd_o
);

  spa_cmd_t q_mem_q [2];
  logic     wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic     push, pop;
  spa_cmd_t c;

  always_comb begin
    c.func      = func_i;
    c.zero      = (request_bytes_i == 16'd0);
    c.too_large = (request_bytes_i > 16'(MaxPoolRequest));
    c.free_null = (free_address_i == 16'd0);
    c.cls       = class_of(request_bytes_i);
    c.base      = free_address_i - 16'd8;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overfull");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: rtl/spa_back.sv
// back end: free lists, link and class memories, chunk carving, result register
// depends on spa_pkg
`timescale 1ns / 1ps
`default_nettype none
module spa_back import spa_pkg::*; #(
  parameter int unsigned HeapChunks = DefHeapChunks
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [4:0]  limit_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_take_o,
  input  wire spa_cmd_t    cmd_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      block_address_o,
  output logic [2:0]       size_class_o
);

  localparam int unsigned Granules = HeapChunks * GranulesPerChunk;
  localparam int unsigned GW = $clog2(Granules);
  localparam int unsigned BW = $clog2(HeapChunks + 1) + 1;
  localparam logic [GW:0] LinkNull = (GW + 1)'(Granules);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_CARVE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [GW:0] link_mem [Granules];
  logic [2:0]  cls_mem  [Granules];
  logic [GW:0] link_rd_q;
  logic [2:0]  cls_rd_q;

  logic [GW:0] heads_q [NumClasses];
  logic [2:0]  state_q;
  logic [BW-1:0] brk_q;
  logic        ready_q;
  spa_cmd_t    cmd_q;
  logic [6:0]  g_q;
  logic [BW-1:0] chunk_q;
  logic [2:0]  ccls_q;
  logic        init_q;
  logic [2:0]  st_q;
  logic [15:0] addr_q;
  logic [2:0]  ocls_q;

  logic [BW-1:0] lim;
  logic          lw_en, cw_en;
  logic [GW-1:0] lw_a, cw_a, rd_a;
  logic [GW:0]   lw_d;
  logic [7:0]    step;
  logic [7:0]    nxt;
  logic [GW-1:0] gbase;
  logic [15:0]   fb;
  logic [GW-1:0] fgran;
  logic          free_ok;

  assign lim = (32'(limit_i) > HeapChunks) ? BW'(HeapChunks) : BW'(limit_i);
  assign step  = 8'd1 << ccls_q;
  assign nxt   = {1'b0, g_q} + step;
  assign gbase = GW'(chunk_q) << 7;
  assign fb    = cmd_q.base;
  assign fgran = GW'(fb >> 5);
  assign free_ok = ((fb & ((16'd32 << cls_rd_q) - 16'd1)) == 16'd0);
  assign rd_a  = (cmd_q.func == FuncFree) ? fgran : heads_q[cmd_q.cls][GW-1:0];

  assign cmd_take_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o        = st_q;
  assign block_address_o = addr_q;
  assign size_class_o    = ocls_q;

  always_comb begin
    lw_en = 1'b0;
    cw_en = 1'b0;
    lw_a  = gbase | GW'(g_q);
    cw_a  = gbase | GW'(g_q);
    lw_d  = nxt[7] ? LinkNull : (GW + 1)'(gbase | GW'(nxt[6:0]));
    if (state_q == S_CARVE) begin
      cw_en = 1'b1;
      lw_en = (init_q ? (g_q >= 7'd2) : 1'b1) &&
              ((g_q & 7'(step - 8'd1)) == 7'd0);
    end else if (state_q == S_POP && cmd_q.func == FuncFree && free_ok) begin
      lw_en = 1'b1;
      lw_a  = fgran;
      lw_d  = heads_q[cls_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) link_mem[lw_a] <= lw_d;
    if (cw_en) cls_mem[cw_a] <= ccls_q;
    link_rd_q <= link_mem[rd_a];
    cls_rd_q  <= cls_mem[rd_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      brk_q   <= '0;
      ready_q <= 1'b0;
      for (int i = 0; i < NumClasses; i++) heads_q[i] <= LinkNull;
      cmd_q   <= '0;
      g_q     <= '0;
      chunk_q <= '0;
      ccls_q  <= '0;
      init_q  <= 1'b0;
      st_q    <= StOk;
      addr_q  <= '0;
      ocls_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            st_q  <= StOk;
            addr_q <= '0;
            ocls_q <= '0;
            if (cmd_i.func == FuncAlloc) begin
              if (cmd_i.zero) begin
                st_q <= StNull;
                state_q <= S_OUT;
              end else if (!ready_q) begin
                if (lim == '0) begin
                  st_q <= StNoMem;
                  state_q <= S_OUT;
                end else begin
                  chunk_q <= '0;
                  ccls_q  <= 3'd1;
                  g_q     <= '0;
                  init_q  <= 1'b1;
                  state_q <= S_CARVE;
                end
              end else begin
                state_q <= S_READ;
              end
            end else if (cmd_i.free_null) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_CARVE: begin
          g_q <= g_q + 7'd1;
          if (g_q == 7'd127) begin
            if (init_q) begin
              init_q     <= 1'b0;
              ready_q    <= 1'b1;
              brk_q      <= BW'(1);
              heads_q[1] <= (GW + 1)'(2);
              state_q    <= S_READ;
            end else begin
              brk_q   <= brk_q + BW'(1);
              heads_q[ccls_q] <= (step[7]) ? LinkNull : (GW + 1)'(gbase | GW'(step[6:0]));
              addr_q  <= 16'(gbase) << 5 | 16'd8;
              ocls_q  <= ccls_q;
              state_q <= S_OUT;
            end
          end
        end
        S_READ: begin
          if (cmd_q.func == FuncAlloc) begin
            if (cmd_q.too_large) begin
              st_q <= StTooLarge;
              state_q <= S_OUT;
            end else if (heads_q[cmd_q.cls] != LinkNull) begin
              state_q <= S_POP;
            end else if (brk_q >= lim) begin
              st_q <= StNoMem;
              ocls_q <= cmd_q.cls;
              state_q <= S_OUT;
            end else begin
              chunk_q <= brk_q;
              ccls_q  <= cmd_q.cls;
              g_q     <= '0;
              state_q <= S_CARVE;
            end
          end else begin
            if (!ready_q || BW'(fb >> 12) >= brk_q || fb < 16'd64 ||
                (fb >> 12) >= 16'(HeapChunks)) begin
              st_q <= StBadAddr;
              state_q <= S_OUT;
            end else begin
              state_q <= S_POP;
            end
          end
        end
        S_POP: begin
          if (cmd_q.func == FuncAlloc) begin
            heads_q[cmd_q.cls] <= link_rd_q;
            addr_q  <= (16'(heads_q[cmd_q.cls][GW-1:0]) << 5) | 16'd8;
            ocls_q  <= cmd_q.cls;
          end else if (!free_ok) begin
            st_q <= StBadAddr;
          end else begin
            heads_q[cls_rd_q] <= (GW + 1)'(fgran);
            ocls_q <= cls_rd_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_brk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= BW'(HeapChunks)) else $error("break beyond heap");
  a_ready_brk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> brk_q != '0) else $error("ready with empty heap");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_stall_i |=> state_q == S_OUT)
    else $error("result dropped under stall");

endmodule
`default_nettype wire

// File: rtl/segregated_pool_allocator.sv
// top level of the segregated pool allocator: config register, front and back ends
// depends on spa_pkg, spa_front, spa_back
//
// usage: requests enter on in_valid_i/in_stall_o with func_i, request_bytes_i
// and free_address_i; one result per request leaves on out_valid_o/out_stall_i
// with status_o, block_address_o and size_class_o, in request order.
// the front end classifies a request and holds up to two in a queue, so it
// takes new requests while a result waits; the back end handles one at a time.
// a request that carves a chunk writes a class for each of its 128 granules
// and a link for each block; the first nonzero allocate with a nonzero
// chunk_limit carves chunk 0 first to set up the heap. the back end takes
// no new request until the result of the last one has left.
// chunk_limit is to be written through cfg_valid_i/cfg_ready_o only while
// idle; the block itself does not enforce this, and ready is always high.
// reset empties all lists, clears the break and the heap set-up flag and
// sets chunk_limit to 16; no clearing pass is needed.
// when out_stall_i is high the result holds and the back end waits.
`timescale 1ns / 1ps
`default_nettype none
module segregated_pool_allocator import spa_pkg::*; #(
  parameter int unsigned HeapChunks = DefHeapChunks
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  chunk_limit_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [15:0] request_bytes_i,
  input  wire logic [15:0] free_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      block_address_o,
  output logic [2:0]       size_class_o
);

  logic [4:0] limit_q;
  logic       cmd_valid, cmd_take;
  spa_cmd_t   cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 5'd16;
    else if (cfg_valid_i) limit_q <= chunk_limit_i;
  end

  spa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .request_bytes_i,
    .free_address_i, .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  spa_back #(.HeapChunks(HeapChunks)) u_back (
    .clk_i, .rst_ni, .limit_i(limit_q), .cmd_valid_i(cmd_valid),
    .cmd_take_o(cmd_take), .cmd_i(cmd), .out_valid_o, .out_stall_i,
    .status_o, .block_address_o, .size_class_o
  );

endmodule
`default_nettype wire
